>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// word formats, command and status codes, cell and scan control
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DepthDefault    = 16;
  localparam int PrioBitsDefault = 16;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_INCR   = 3'd3,
    CMD_DECR   = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_INCR,
    OP_DECR,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
    logic [4:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               queue_nonempty;
    logic signed [15:0] top_priority;
    logic signed [15:0] bottom_priority;
    logic signed [31:0] largest_value;
    logic signed [31:0] read_value;
    logic signed [15:0] read_priority;
  } out_word_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e    op;
    logic [4:0]  pos;
    logic [31:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic       start;
    logic       step;
    logic       decr;
    logic       read_en;
    logic [4:0] pos;
  } scan_ctrl_t;

endpackage

>>> sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted value/priority queue in a row of cells
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i/in_ready_o carries one command word: insert,
//   remove or read at a 1-based position, increment all, decrement all,
//   query. output channel out_valid_o/out_ready_i returns exactly one result
//   word per command with status, count, head/last priority, largest value
//   and read data.
//   the command itself is applied to the whole cell row in the cycle it is
//   accepted; the row then rotates once through all DEPTH cells so a summary
//   unit can look at every entry at the head. the result word is registered
//   after the sweep, and no new command is taken until the block is back
//   in idle with that word handed to the output register.
//   in_ready_o is high only between commands. a finished word sits in the
//   output register; a stalled receiver holds the block in its finish step
//   until the register frees, without losing anything.
//   reset empties the queue (count zero); cell contents are not cleared and
//   are never looked at beyond the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::DepthDefault,
  parameter int PRIORITY_BITS = spq_pkg::PrioBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_word_t out_word_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PosW = (CntW > 5) ? CntW : 5;
  localparam int PW   = PRIORITY_BITS;
  localparam longint PMaxL = (64'sd1 <<< (PW - 1)) - 64'sd1;
  localparam longint PMinL = -(64'sd1 <<< (PW - 1));

  // control
  fsm_e            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_word_q, out_word_d;

  // per-command context held through the sweep
  status_e    status_q, status_d;
  logic       read_ok_q, read_ok_d;
  logic       decr_q, decr_d;
  logic [4:0] pos_q, pos_d;

  logic       accept;
  cell_ctrl_t cell_ctrl;
  scan_ctrl_t scan_ctrl;
  cmd_e       cmd;

  logic [PW-1:0]   new_pri;
  longint          pri_wide;
  logic [PosW-1:0] pos_w, cnt_w;
  logic            is_empty, is_full, pos_bad;

  // cell row
  logic [31:0]   cell_value [DEPTH];
  logic [PW-1:0] cell_pri   [DEPTH];
  logic          cell_stay  [DEPTH];

  // sweep results
  logic            scan_last;
  logic [CntW-1:0] scan_count;
  logic [31:0]     scan_max, scan_rd_value;
  logic [PW-1:0]   scan_top, scan_bot, scan_rd_pri;

  assign accept = in_valid_i && in_ready_o;
  assign cmd    = cmd_e'(in_word_i.command);

  // inserted priority saturates to the stored width
  always_comb begin
    pri_wide = longint'(in_word_i.item_priority);
    if (pri_wide > PMaxL) pri_wide = PMaxL;
    if (pri_wide < PMinL) pri_wide = PMinL;
    new_pri = pri_wide[PW-1:0];
  end

  assign pos_w    = PosW'(in_word_i.position);
  assign cnt_w    = PosW'(count_q);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign pos_bad  = (pos_w == '0) || (pos_w > cnt_w);

  // command decode and sequencing
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    status_d        = status_q;
    read_ok_d       = read_ok_q;
    decr_d          = decr_q;
    pos_d           = pos_q;
    cell_ctrl.op    = OP_HOLD;
    cell_ctrl.pos   = in_word_i.position;
    cell_ctrl.value = in_word_i.item_value;
    scan_ctrl.start = 1'b0;
    scan_ctrl.step  = 1'b0;
    scan_ctrl.decr  = decr_q;
    scan_ctrl.read_en = read_ok_q;
    scan_ctrl.pos   = pos_q;
    in_ready_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          status_d  = ST_OK;
          read_ok_d = 1'b0;
          decr_d    = 1'b0;
          pos_d     = in_word_i.position;
          case (cmd)
            CMD_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                cell_ctrl.op = OP_INSERT;
                count_d      = count_q + 1'b1;
              end
            end
            CMD_REMOVE, CMD_READ: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (pos_bad) begin
                status_d = ST_RANGE;
              end else if (cmd == CMD_REMOVE) begin
                cell_ctrl.op = OP_REMOVE;
                count_d      = count_q - 1'b1;
              end else begin
                read_ok_d = 1'b1;
              end
            end
            CMD_INCR: begin
              cell_ctrl.op = OP_INCR;
            end
            CMD_DECR: begin
              cell_ctrl.op = OP_DECR;
              decr_d       = 1'b1;
            end
            default: begin
              // query and the unused codes
              if (is_empty) status_d = ST_EMPTY;
            end
          endcase
          scan_ctrl.start = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        // one full turn of the row brings every cell back to its place
        cell_ctrl.op   = OP_ROTATE;
        scan_ctrl.step = 1'b1;
        if (scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        count_d = scan_count;
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    out_word_d                 = out_word_q;
    out_valid_d                = out_valid_q && !out_ready_i;
    if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
      out_valid_d                = 1'b1;
      out_word_d.status          = status_q;
      out_word_d.entry_count     = 5'(scan_count);
      out_word_d.queue_nonempty  = (scan_count != '0);
      out_word_d.top_priority    = '0;
      out_word_d.bottom_priority = '0;
      out_word_d.largest_value   = '0;
      out_word_d.read_value      = '0;
      out_word_d.read_priority   = '0;
      if (scan_count != '0) begin
        out_word_d.top_priority    = 16'(32'(signed'(scan_top)));
        out_word_d.bottom_priority = 16'(32'(signed'(scan_bot)));
        out_word_d.largest_value   = scan_max;
      end
      if (read_ok_q) begin
        out_word_d.read_value    = scan_rd_value;
        out_word_d.read_priority = 16'(32'(signed'(scan_rd_pri)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    status_q   <= status_d;
    read_ok_q  <= read_ok_d;
    decr_q     <= decr_d;
    pos_q      <= pos_d;
  end

  // the cell row, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int Right = (i + 1) % DEPTH;
    logic          left_stay;
    logic [31:0]   left_value;
    logic [PW-1:0] left_pri;
    logic          occ;

    if (i == 0) begin : g_head
      assign left_stay  = 1'b0;
      assign left_value = '0;
      assign left_pri   = '0;
    end else begin : g_body
      assign left_stay  = cell_stay[i-1];
      assign left_value = cell_value[i-1];
      assign left_pri   = cell_pri[i-1];
    end

    assign occ = (count_q > CntW'(i));

    spq_cell #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .IDX           (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .new_pri_i     (new_pri),
      .occ_i         (occ),
      .left_stay_i   (left_stay),
      .left_value_i  (left_value),
      .left_pri_i    (left_pri),
      .right_value_i (cell_value[Right]),
      .right_pri_i   (cell_pri[Right]),
      .stay_o        (cell_stay[i]),
      .value_o       (cell_value[i]),
      .pri_o         (cell_pri[i])
    );
  end

  spq_scan #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .count_i      (count_d),
    .head_value_i (cell_value[0]),
    .head_pri_i   (cell_pri[0]),
    .last_o       (scan_last),
    .count_o      (scan_count),
    .max_o        (scan_max),
    .top_pri_o    (scan_top),
    .bottom_pri_o (scan_bot),
    .read_value_o (scan_rd_value),
    .read_pri_o   (scan_rd_pri)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> sv/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one entry of the sorted cell row
// holds a value/priority pair and trades it with its neighbors
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 16,
  parameter int IDX           = 0
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctrl_t      ctrl_i,
  input  logic [PRIORITY_BITS-1:0] new_pri_i,
  input  logic                     occ_i,
  input  logic                     left_stay_i,
  input  logic [31:0]              left_value_i,
  input  logic [PRIORITY_BITS-1:0] left_pri_i,
  input  logic [31:0]              right_value_i,
  input  logic [PRIORITY_BITS-1:0] right_pri_i,
  output logic                     stay_o,
  output logic [31:0]              value_o,
  output logic [PRIORITY_BITS-1:0] pri_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PosW = (CntW > 5) ? CntW : 5;
  localparam logic [PosW-1:0] MyPos = PosW'(IDX + 1);
  localparam logic [PRIORITY_BITS-1:0] PMax = {1'b0, {(PRIORITY_BITS-1){1'b1}}};
  localparam logic [PRIORITY_BITS-1:0] PMin = {1'b1, {(PRIORITY_BITS-1){1'b0}}};

  logic [31:0]              value_q, value_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic                     stay;

  always_comb begin
    // the head keeps its place on a tie, later cells only when strictly higher
    if (IDX == 0) begin
      stay = occ_i && ($signed(pri_q) >= $signed(new_pri_i));
    end else begin
      stay = occ_i && ($signed(pri_q) > $signed(new_pri_i));
    end
  end

  always_comb begin
    value_d = value_q;
    pri_d   = pri_q;
    case (ctrl_i.op)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        if (!stay) begin
          if (IDX == 0 || left_stay_i) begin
            value_d = ctrl_i.value;
            pri_d   = new_pri_i;
          end else begin
            value_d = left_value_i;
            pri_d   = left_pri_i;
          end
        end
      end
      OP_REMOVE: begin
        if (MyPos >= PosW'(ctrl_i.pos)) begin
          value_d = right_value_i;
          pri_d   = right_pri_i;
        end
      end
      OP_INCR: begin
        if (pri_q != PMax) pri_d = pri_q + 1'b1;
      end
      OP_DECR: begin
        if (pri_q != PMin) pri_d = pri_q - 1'b1;
      end
      OP_ROTATE: begin
        value_d = right_value_i;
        pri_d   = right_pri_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pri_q   <= pri_d;
  end

  assign stay_o  = stay;
  assign value_o = value_q;
  assign pri_o   = pri_q;

endmodule

>>> sv/spq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_scan: summary sweep over the rotating cell row
// watches the head cell each step: count, max, top/bottom priority, read data
// ----------------------------------------------------------------------------
module spq_scan #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spq_pkg::scan_ctrl_t                ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]         count_i,
  input  logic [31:0]                        head_value_i,
  input  logic [PRIORITY_BITS-1:0]           head_pri_i,
  output logic                               last_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o,
  output logic [31:0]                        max_o,
  output logic [PRIORITY_BITS-1:0]           top_pri_o,
  output logic [PRIORITY_BITS-1:0]           bottom_pri_o,
  output logic [31:0]                        read_value_o,
  output logic [PRIORITY_BITS-1:0]           read_pri_o
);
  import spq_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PosW = (CntW > 5) ? CntW : 5;

  logic [IdxW-1:0]          k_q, k_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [31:0]              max_q, max_d;
  logic [PRIORITY_BITS-1:0] top_q, top_d, bot_q, bot_d;
  logic [31:0]              rd_val_q, rd_val_d;
  logic [PRIORITY_BITS-1:0] rd_pri_q, rd_pri_d;
  logic                     in_range;

  assign in_range = CntW'(k_q) < cnt_q;

  always_comb begin
    k_d      = k_q;
    cnt_d    = cnt_q;
    max_d    = max_q;
    top_d    = top_q;
    bot_d    = bot_q;
    rd_val_d = rd_val_q;
    rd_pri_d = rd_pri_q;
    if (ctrl_i.start) begin
      k_d   = '0;
      cnt_d = count_i;
    end else if (ctrl_i.step) begin
      k_d = k_q + 1'b1;
      if (in_range) begin
        if (ctrl_i.decr && head_pri_i == '0) begin
          // entry hit zero: it and everything behind it drop out
          cnt_d = CntW'(k_q);
        end else begin
          if (k_q == '0) begin
            max_d = head_value_i;
            top_d = head_pri_i;
          end else if ($signed(head_value_i) > $signed(max_q)) begin
            max_d = head_value_i;
          end
          bot_d = head_pri_i;
          if (ctrl_i.read_en && PosW'(ctrl_i.pos) == PosW'(k_q) + 1'b1) begin
            rd_val_d = head_value_i;
            rd_pri_d = head_pri_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      cnt_q <= '0;
    end else begin
      k_q   <= k_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q    <= max_d;
    top_q    <= top_d;
    bot_q    <= bot_d;
    rd_val_q <= rd_val_d;
    rd_pri_q <= rd_pri_d;
  end

  assign last_o       = ctrl_i.step && (k_q == IdxW'(DEPTH - 1));
  assign count_o      = cnt_q;
  assign max_o        = max_q;
  assign top_pri_o    = top_q;
  assign bottom_pri_o = bot_q;
  assign read_value_o = rd_val_q;
  assign read_pri_o   = rd_pri_q;

endmodule
